### src/crcfpr_pkg.sv
package crcfpr_pkg;

  localparam int unsigned DefaultBufferDepth = 256;

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'h1021;
  localparam logic [15:0] CrcTop  = 16'h8000;

  localparam logic [7:0] SyncFirstReset  = 8'hAA;
  localparam logic [7:0] SyncSecondReset = 8'h55;
  localparam logic [8:0] MaxLengthReset  = 9'd256;

  typedef enum logic [1:0] {
    REG_SYNC_FIRST  = 2'd0,
    REG_SYNC_SECOND = 2'd1,
    REG_MAX_LENGTH  = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_BUSY      = 2'd0,
    ST_COMPLETE  = 2'd1,
    ST_ERROR     = 2'd2,
    ST_READ_DATA = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    PH_SYNC1  = 3'd0,
    PH_SYNC2  = 3'd1,
    PH_LEN_LO = 3'd2,
    PH_LEN_HI = 3'd3,
    PH_DATA   = 3'd4,
    PH_CRC_LO = 3'd5,
    PH_CRC_HI = 3'd6
  } phase_t;

  // CRC-16/CCITT-FALSE update over one byte, MSB first.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] data);
    logic [15:0] c;
    c = crc_in ^ {data, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if ((c & CrcTop) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

### src/crc_framed_packet_receiver.sv
// Byte-stream frame receiver. Each input item is either a line byte (tuser 0) or a read
// of the payload buffer (tuser 1). A frame is two sync bytes, a little-endian 16-bit
// length, the payload and a little-endian CRC-16/CCITT-FALSE over length and payload.
// Every item yields exactly one result item: in progress, frame complete with its
// length, frame error, or read data. The block takes one item per cycle unless a held
// result stalls it, and presents its result in the cycle after acceptance; the buffer
// read port is registered. The output register holds a result while the sink stalls,
// and a new item is taken in the same cycle the held result is taken. Reads of buffer
// entries never written return undefined data; reads beyond the buffer return zero.
module crc_framed_packet_receiver #(
  parameter int unsigned BUFFER_DEPTH = crcfpr_pkg::DefaultBufferDepth
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,    // [7:0] line_byte, [15:8] read_index
  input  logic        s_tuser,    // [0] mode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,    // [8:0] pkt_length, [16:9] read_data, rest zero
  output logic [1:0]  m_tuser,    // [1:0] status
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data
);
  import crcfpr_pkg::*;

  localparam int unsigned AW  = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int unsigned FXW = (AW > 9) ? AW : 9;
  localparam int unsigned IXW = (AW > 8) ? AW : 8;
  localparam int unsigned LW  = (BUFFER_DEPTH > 65535) ? 17 : 17;

  // Configuration registers
  logic [7:0] sync_first;
  logic [7:0] sync_second;
  logic [8:0] max_length;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_first  <= SyncFirstReset;
      sync_second <= SyncSecondReset;
      max_length  <= MaxLengthReset;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SYNC_FIRST:  sync_first  <= cfg_data[7:0];
        REG_SYNC_SECOND: sync_second <= cfg_data[7:0];
        REG_MAX_LENGTH:  max_length  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Handshake
  logic out_valid;
  logic accept;

  assign s_tready = !out_valid || m_tready;
  assign accept   = s_tvalid && s_tready;

  logic [7:0] line_byte;
  logic [7:0] read_index;
  assign line_byte  = s_tdata[7:0];
  assign read_index = s_tdata[15:8];

  // Receive state
  phase_t      phase, phase_next;
  logic [7:0]  len_lo, len_lo_next;
  logic [8:0]  exp_len, exp_len_next;
  logic [8:0]  fill, fill_next;
  logic [15:0] crc, crc_next;
  logic [7:0]  crc_lo, crc_lo_next;
  status_t     status_next;
  logic [8:0]  flen_next;
  logic        wr_en;

  logic [15:0]   full_len;
  logic [LW-1:0] limit;
  logic [8:0]    fill_inc;
  logic [FXW-1:0] fill_x;

  assign full_len = {line_byte, len_lo};
  assign limit = ({8'h00, max_length} > LW'(BUFFER_DEPTH)) ? LW'(BUFFER_DEPTH)
                                                           : {8'h00, max_length};
  assign fill_inc = fill + 9'd1;
  assign fill_x   = FXW'(fill);

  always_comb begin
    phase_next   = phase;
    len_lo_next  = len_lo;
    exp_len_next = exp_len;
    fill_next    = fill;
    crc_next     = crc;
    crc_lo_next  = crc_lo;
    status_next  = ST_BUSY;
    flen_next    = 9'd0;
    wr_en        = 1'b0;
    unique case (phase)
      PH_SYNC1: begin
        if (line_byte == sync_first) begin
          phase_next = PH_SYNC2;
        end
      end
      PH_SYNC2: begin
        // The second sync value is checked first so that equal sync values advance.
        priority if (line_byte == sync_second) begin
          phase_next = PH_LEN_LO;
        end else if (line_byte != sync_first) begin
          phase_next = PH_SYNC1;
        end else begin
          phase_next = PH_SYNC2;
        end
      end
      PH_LEN_LO: begin
        len_lo_next = line_byte;
        crc_next    = crc_byte(CrcInit, line_byte);
        phase_next  = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        if (full_len == 16'd0 || {1'b0, full_len} > limit) begin
          phase_next   = PH_SYNC1;
          len_lo_next  = 8'd0;
          exp_len_next = 9'd0;
          fill_next    = 9'd0;
          crc_next     = CrcInit;
          crc_lo_next  = 8'd0;
          status_next  = ST_ERROR;
        end else begin
          exp_len_next = full_len[8:0];
          crc_next     = crc_byte(crc, line_byte);
          fill_next    = 9'd0;
          phase_next   = PH_DATA;
        end
      end
      PH_DATA: begin
        wr_en     = ({23'd0, fill} < 32'(BUFFER_DEPTH));
        fill_next = fill_inc;
        crc_next  = crc_byte(crc, line_byte);
        if (fill_inc >= exp_len) begin
          phase_next = PH_CRC_LO;
        end
      end
      PH_CRC_LO: begin
        crc_lo_next = line_byte;
        phase_next  = PH_CRC_HI;
      end
      PH_CRC_HI: begin
        if ({line_byte, crc_lo} != crc) begin
          status_next = ST_ERROR;
        end else begin
          status_next = ST_COMPLETE;
          flen_next   = exp_len;
        end
        phase_next   = PH_SYNC1;
        len_lo_next  = 8'd0;
        exp_len_next = 9'd0;
        fill_next    = 9'd0;
        crc_next     = CrcInit;
        crc_lo_next  = 8'd0;
      end
      default: begin
        phase_next   = PH_SYNC1;
        len_lo_next  = 8'd0;
        exp_len_next = 9'd0;
        fill_next    = 9'd0;
        crc_next     = CrcInit;
        crc_lo_next  = 8'd0;
        status_next  = ST_ERROR;
      end
    endcase
  end

  logic rx_accept;
  assign rx_accept = accept && !s_tuser;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_SYNC1;
      len_lo  <= 8'd0;
      exp_len <= 9'd0;
      fill    <= 9'd0;
      crc     <= CrcInit;
      crc_lo  <= 8'd0;
    end else if (rx_accept) begin
      phase   <= phase_next;
      len_lo  <= len_lo_next;
      exp_len <= exp_len_next;
      fill    <= fill_next;
      crc     <= crc_next;
      crc_lo  <= crc_lo_next;
    end
  end

  // Payload buffer: one write port for received bytes, one registered read port.
  // A write and a read never share an edge, since only one item is taken per cycle.
  logic [7:0]     mem [BUFFER_DEPTH];
  logic [7:0]     rd_q;
  logic [IXW-1:0] idx_x;
  logic           idx_ok;
  logic           rd_en;

  assign idx_x  = IXW'(read_index);
  assign idx_ok = ({24'd0, read_index} < 32'(BUFFER_DEPTH));
  assign rd_en  = accept && s_tuser && idx_ok;

  always_ff @(posedge clk) begin
    if (rx_accept && wr_en) begin
      mem[fill_x[AW-1:0]] <= line_byte;
    end
    if (rd_en) begin
      rd_q <= mem[idx_x[AW-1:0]];
    end
  end

  // Output register
  status_t    out_status;
  logic [8:0] out_flen;
  logic       out_rd_ok;
  logic [7:0] out_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_status <= s_tuser ? ST_READ_DATA : status_next;
      out_flen   <= s_tuser ? 9'd0 : flen_next;
      out_rd_ok  <= s_tuser && idx_ok;
    end
  end

  assign out_byte = out_rd_ok ? rd_q : 8'd0;

  assign m_tvalid = out_valid;
  assign m_tuser  = out_status;
  assign m_tdata  = {7'd0, out_byte, out_flen};

endmodule
